FILE: design/rgbc_pkg.sv
// Shared types, register codes and constants for the 3x3 RGB convolution block.
// No dependencies; every other file of the block imports this package.
package rgbc_pkg;

   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 48;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 16;
   localparam int COEF_PITCH     = 16;
   localparam int PIXEL_MAX      = 255;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_KERNEL_TOP,
      CSR_KERNEL_MID,
      CSR_KERNEL_BOTTOM
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // index 0 is the row above the centre, 2 the row below
   typedef pixel_type [2:0] column_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       pad_item;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic       result;
      logic       frame_end;
      logic [2:0] row_use;
      logic [2:0] col_use;
   } tap_ctrl_type;

   function automatic logic [7:0] pixel_chan(input pixel_type p, input logic [1:0] ch);
      logic [7:0] v;
      case (ch)
         2'd0:    v = p.red;
         2'd1:    v = p.green;
         default: v = p.blue;
      endcase
      return v;
   endfunction

endpackage

FILE: design/rgbc_line_store.sv
// Two line stores (row above, centre row) with registered reads and forwarding.
// Depends on rgbc_pkg for the pixel and column types.
module rgbc_line_store
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic [AW-1:0] addr,
   input  pixel_type     pixel,
   output logic          col_valid,
   output column_type    column
);

   pixel_type upper_mem [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];

   logic          stage_valid_ff;
   logic [AW-1:0] addr_ff;
   pixel_type     pix_ff;
   pixel_type     upper_q_ff;
   pixel_type     middle_q_ff;
   logic          fwd_ff;
   pixel_type     fwd_upper_ff;
   pixel_type     fwd_middle_ff;
   pixel_type     top_eff;
   pixel_type     mid_eff;

   assign top_eff = fwd_ff ? fwd_upper_ff : upper_q_ff;
   assign mid_eff = fwd_ff ? fwd_middle_ff : middle_q_ff;

   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         upper_mem[addr_ff] <= mid_eff;
      end
      if (take) begin
         upper_q_ff <= upper_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         middle_mem[addr_ff] <= pix_ff;
      end
      if (take) begin
         middle_q_ff <= middle_mem[addr];
      end
   end

   // bypass the write landing on the same entry at the edge of the read
   always_ff @(posedge clock) begin
      if (take) begin
         fwd_ff        <= stage_valid_ff && (addr_ff == addr);
         fwd_upper_ff  <= mid_eff;
         fwd_middle_ff <= pix_ff;
         addr_ff       <= addr;
         pix_ff        <= pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= take;
      end
   end

   assign col_valid = stage_valid_ff;
   assign column    = {pix_ff, mid_eff, top_eff};

endmodule

FILE: design/rgbc_cell.sv
// One window column: holds three pixels, weighs them and sums per colour.
// Depends on rgbc_pkg for the column type and channel select.
module rgbc_cell
   import rgbc_pkg::*;
#(
   parameter int COEF_BITS = 16,
   localparam int PROD_W = COEF_BITS + 9,
   localparam int COL_W  = PROD_W + 2
) (
   input  logic                   clock,
   input  logic                   shift_en,
   input  column_type             col_in,
   input  logic [3*COEF_BITS-1:0] coef_col,
   input  logic [2:0]             row_use,
   input  logic                   col_use,
   output column_type             col_out,
   output logic [3*COL_W-1:0]     sum_out
);

   column_type               hold_ff;
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [COL_W-1:0]  sum_in [3];
   logic signed [COL_W-1:0]  sum_ff [3];

   always_ff @(posedge clock) begin
      if (shift_en) begin
         hold_ff <= col_in;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int ch = 0; ch < 3; ch++) begin
            prod_in[r][ch] = '0;
            if (row_use[r] && col_use) begin
               prod_in[r][ch] = $signed({1'b0, pixel_chan(hold_ff[r], 2'(ch))}) *
                                $signed(coef_col[r*COEF_BITS +: COEF_BITS]);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = COL_W'(prod_ff[0][ch]) + COL_W'(prod_ff[1][ch]) +
                      COL_W'(prod_ff[2][ch]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_out[ch*COL_W +: COL_W] = sum_ff[ch];
      end
   end

   assign col_out = hold_ff;

endmodule

FILE: design/rgbc_out_fifo.sv
// Result queue between the arithmetic pipeline and the response channel.
// Depends on rgbc_pkg for the response type.
module rgbc_out_fifo
   import rgbc_pkg::*;
#(
   parameter int DEPTH = 8,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_type       push_data,
   input  logic          pop,
   output logic          out_valid,
   output rsp_type       out_data,
   output logic [CW-1:0] count
);

   rsp_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

FILE: design/rgb_conv3x3_clamp.sv
// Top level: streaming zero-padded 3x3 convolution of RGB888 pixels, clamped to 0..255.
// Depends on rgbc_pkg, rgbc_line_store, rgbc_cell and rgbc_out_fifo.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall  req_data (req_type)
//   rsp_      out        rsp_valid/rsp_stall  rsp_data (rsp_type)
//   csr_      in         csr_wr_en            csr_index, csr_wr_data
//
// One request per clock while req_stall is low. A result can be taken once the request that
// completes its window (frame_width+1 requests after its centre pixel) has passed the
// line store read register, the window shift register, the product and column sum
// registers of the cells, and the result queue write, fed by the combinational
// total and clamp.
// Reset is synchronous; line stores are not cleared and need no clearing pass.
// An eight-entry result queue absorbs rsp_stall; req_stall rises when results
// in flight plus queued results reach eight.
module rgb_conv3x3_clamp
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int COEF_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int AW         = $clog2(MAX_WIDTH);
   localparam int IS_W       = $clog2(MAX_WIDTH + 2);
   localparam int PROD_W     = COEF_BITS + 9;
   localparam int COL_W      = PROD_W + 2;
   localparam int SUM_W      = PROD_W + 4;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam int OCC_W      = $clog2(FIFO_DEPTH + 5 + 1);

   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [2:0][2:0][COEF_BITS-1:0] kernel_ff;

   logic [IS_W-1:0]           items_seen_ff;
   logic [IS_W-1:0]           items_seen_in;
   logic [AW-1:0]             column_count_ff;
   logic [AW-1:0]             column_count_in;
   logic [FRAME_HEIGHT_W-1:0] row_count_ff;
   logic [FRAME_HEIGHT_W-1:0] row_count_in;

   logic [IS_W-1:0]           w_eff;
   logic [FRAME_HEIGHT_W-1:0] h_eff;
   logic                      valid_now;
   logic                      last_col;
   logic                      last_row;
   logic [AW-1:0]             col_addr;
   tap_ctrl_type              ctrl_in;
   pixel_type                 bot_pixel;
   logic                      accept;

   tap_ctrl_type              s1_ctrl_ff;
   tap_ctrl_type              s2_ctrl_ff;
   logic                      s2_res_ff;
   logic                      s3_res_ff;
   logic                      s3_end_ff;
   logic                      s4_res_ff;
   logic                      s4_end_ff;

   logic                      lines_valid;
   column_type                cell_col [4];
   logic [3*COL_W-1:0]        cell_sum [3];

   logic signed [SUM_W-1:0]   total [3];
   logic [7:0]                clamped [3];
   rsp_type                   push_data;
   logic                      pop;
   logic [FIFO_CW-1:0]        fifo_count;
   logic [OCC_W-1:0]          occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         kernel_ff       <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_ff  <= csr_wr_data[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff <= csr_wr_data[FRAME_HEIGHT_W-1:0];
            CSR_KERNEL_TOP: begin
               for (int c = 0; c < 3; c++) begin
                  kernel_ff[0][c] <= csr_wr_data[c*COEF_PITCH +: COEF_BITS];
               end
            end
            CSR_KERNEL_MID: begin
               for (int c = 0; c < 3; c++) begin
                  kernel_ff[1][c] <= csr_wr_data[c*COEF_PITCH +: COEF_BITS];
               end
            end
            CSR_KERNEL_BOTTOM: begin
               for (int c = 0; c < 3; c++) begin
                  kernel_ff[2][c] <= csr_wr_data[c*COEF_PITCH +: COEF_BITS];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = IS_W'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = IS_W'(MAX_WIDTH);
      end else begin
         w_eff = IS_W'(frame_width_ff);
      end
      h_eff = (frame_height_ff == '0) ? FRAME_HEIGHT_W'(1) : frame_height_ff;

      valid_now = items_seen_ff > w_eff;
      last_col  = (IS_W'(column_count_ff) + IS_W'(1)) >= w_eff;
      last_row  = ({1'b0, row_count_ff} + 17'd1) >= {1'b0, h_eff};

      if (items_seen_ff < w_eff) begin
         col_addr = items_seen_ff[AW-1:0];
      end else if (!valid_now || last_col) begin
         col_addr = '0;
      end else begin
         col_addr = column_count_ff + AW'(1);
      end

      ctrl_in.result    = valid_now;
      ctrl_in.frame_end = valid_now && last_col && last_row;
      ctrl_in.row_use   = {!last_row, 1'b1, row_count_ff != '0};
      ctrl_in.col_use   = {!last_col, 1'b1, column_count_ff != '0};

      items_seen_in   = items_seen_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (!valid_now) begin
            items_seen_in = items_seen_ff + IS_W'(1);
         end else if (last_col && last_row) begin
            items_seen_in   = '0;
            column_count_in = '0;
            row_count_in    = '0;
         end else if (last_col) begin
            column_count_in = '0;
            row_count_in    = row_count_ff + FRAME_HEIGHT_W'(1);
         end else begin
            column_count_in = column_count_ff + AW'(1);
         end
      end
   end

   assign bot_pixel = req_data.pad_item ? '0 :
                      {req_data.red_in, req_data.green_in, req_data.blue_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         items_seen_ff   <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         items_seen_ff   <= items_seen_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // results in flight are counted against queue room before they exist
   assign occupancy = OCC_W'(fifo_count) + OCC_W'(lines_valid && s1_ctrl_ff.result) +
                      OCC_W'(s2_res_ff) + OCC_W'(s3_res_ff) + OCC_W'(s4_res_ff);
   assign req_stall = reset || (occupancy >= OCC_W'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;

   rgbc_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_lines (
      .clock     (clock),
      .reset     (reset),
      .take      (accept),
      .addr      (col_addr),
      .pixel     (bot_pixel),
      .col_valid (lines_valid),
      .column    (cell_col[3])
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= ctrl_in;
      end
      s2_ctrl_ff <= s1_ctrl_ff;
      s3_end_ff  <= s2_ctrl_ff.frame_end;
      s4_end_ff  <= s3_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_res_ff <= 1'b0;
         s3_res_ff <= 1'b0;
         s4_res_ff <= 1'b0;
      end else begin
         s2_res_ff <= lines_valid && s1_ctrl_ff.result;
         s3_res_ff <= s2_res_ff;
         s4_res_ff <= s3_res_ff;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_cell
      rgbc_cell #(
         .COEF_BITS (COEF_BITS)
      ) u_cell (
         .clock    (clock),
         .shift_en (lines_valid),
         .col_in   (cell_col[c+1]),
         .coef_col ({kernel_ff[2][c], kernel_ff[1][c], kernel_ff[0][c]}),
         .row_use  (s2_ctrl_ff.row_use),
         .col_use  (s2_ctrl_ff.col_use[c]),
         .col_out  (cell_col[c]),
         .sum_out  (cell_sum[c])
      );
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         total[ch] = SUM_W'($signed(cell_sum[0][ch*COL_W +: COL_W])) +
                     SUM_W'($signed(cell_sum[1][ch*COL_W +: COL_W])) +
                     SUM_W'($signed(cell_sum[2][ch*COL_W +: COL_W]));
         if (total[ch] < 0) begin
            clamped[ch] = '0;
         end else if (total[ch] > SUM_W'(PIXEL_MAX)) begin
            clamped[ch] = 8'(PIXEL_MAX);
         end else begin
            clamped[ch] = total[ch][7:0];
         end
      end
      push_data.red_out   = clamped[0];
      push_data.green_out = clamped[1];
      push_data.blue_out  = clamped[2];
      push_data.frame_end = s4_end_ff;
   end

   assign pop = rsp_valid && !rsp_stall;

   rgbc_out_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s4_res_ff),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s4_res_ff |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)))
      else $error("result queue overrun");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && ctrl_in.frame_end) |=> (items_seen_ff == '0) && (row_count_ff == '0))
      else $error("counters not cleared after frame end");

   a_window_shift: assert property (@(posedge clock) disable iff (reset)
      lines_valid |=> (cell_col[0] === $past(cell_col[1])))
      else $error("window column not handed on");

   a_read_source: assert property (@(posedge clock) disable iff (reset)
      lines_valid |-> $past(accept))
      else $error("line store stage without request");

endmodule
